// ----- rtl/ccb_pkg.sv -----
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and constants for the compressed card bitmap core.
// ----------------------------------------------------------------------------
package ccb_pkg;

   // Bitmap geometry
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned NUM_WORDS = 1024;
   localparam int unsigned ADDR_W    = $clog2(NUM_WORDS);
   localparam int unsigned POS_W     = $clog2(WORD_BITS);
   localparam int unsigned CARD_W    = 16;

   // Scan walks the word in groups of LANE_BITS
   localparam int unsigned LANE_BITS = 8;
   localparam int unsigned LANE_W    = $clog2(LANE_BITS);
   localparam int unsigned GROUP_W   = $clog2(WORD_BITS / LANE_BITS);

   // Queue depths
   localparam int unsigned OP_QUEUE_DEPTH  = 4;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   // Command codes
   localparam logic [2:0] CMD_BEGIN_REBUILD = 3'd0;
   localparam logic [2:0] CMD_CARD_STATE    = 3'd1;
   localparam logic [2:0] CMD_MARK_DIRTY    = 3'd2;
   localparam logic [2:0] CMD_QUERY_CARD    = 3'd3;
   localparam logic [2:0] CMD_SCAN_WORD     = 3'd4;

   // Card state codes
   localparam logic [2:0] CS_CLEAN           = 3'd0;
   localparam logic [2:0] CS_GLOBAL_SCAN     = 3'd1;
   localparam logic [2:0] CS_REMEMBERED_GLOB = 3'd2;
   localparam logic [2:0] CS_REMEMBERED      = 3'd3;
   localparam logic [2:0] CS_DIRTY           = 3'd4;
   localparam logic [2:0] CS_PARTIAL_SCAN    = 3'd5;

   typedef struct packed {
      logic [2:0]        command;
      logic [9:0]        word_index;
      logic [CARD_W-1:0] card_index;
      logic [2:0]        card_state;
   } req_type;

   typedef struct packed {
      logic [CARD_W-1:0] card_number;
      logic              dirty;
      logic              bad_state;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CARD  = 2'd0,
      OP_MARK  = 2'd1,
      OP_QUERY = 2'd2,
      OP_SCAN  = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [ADDR_W-1:0]    word;
      logic [POS_W-1:0]     bit_pos;
      logic [CARD_W-1:0]    card;
      logic                 dirty;
      logic                 bad;
      logic                 write_en;
      logic [WORD_BITS-1:0] write_data;
   } op_type;

endpackage

// ----- rtl/ccb_fifo.sv -----
// ----------------------------------------------------------------------------
// ccb_fifo
// Small synchronous queue with full and empty flags (DEPTH of 2 or more).
// ----------------------------------------------------------------------------
module ccb_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/ccb_front.sv -----
// ----------------------------------------------------------------------------
// ccb_front
// Decode commands, classify card states and pack rebuild words.
// ----------------------------------------------------------------------------
module ccb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ccb_pkg::req_type req_item,
   output logic             req_full,
   output logic             op_push,
   output ccb_pkg::op_type  op_item,
   input  logic             op_full
);
   import ccb_pkg::*;

   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [WORD_BITS-1:0] partial_ff, partial_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 accept;
   logic                 state_dirty, card_bad;
   logic [WORD_BITS-1:0] packed_word;

   assign req_full = op_full;
   assign accept   = req_push & ~op_full;

   always_comb begin
      state_dirty = 1'b0;
      card_bad    = 1'b0;
      unique case (req_item.card_state) inside
         CS_CLEAN, CS_GLOBAL_SCAN: ;
         CS_REMEMBERED_GLOB, CS_REMEMBERED, CS_DIRTY, CS_PARTIAL_SCAN: state_dirty = 1'b1;
         default: card_bad = 1'b1;
      endcase
   end

   assign packed_word = partial_ff | (WORD_BITS'(state_dirty) << pos_ff);

   always_comb begin
      ptr_in     = ptr_ff;
      partial_in = partial_ff;
      pos_in     = pos_ff;
      op_push    = 1'b0;
      op_item    = '0;
      op_item.word = req_item.word_index;
      unique case (req_item.command)
         CMD_BEGIN_REBUILD: begin
            if (accept) begin
               ptr_in     = req_item.word_index;
               partial_in = '0;
               pos_in     = '0;
            end
         end
         CMD_CARD_STATE: begin
            op_push            = accept;
            op_item.kind       = OP_CARD;
            op_item.word       = ptr_ff;
            op_item.bit_pos    = pos_ff;
            op_item.card       = {ptr_ff, pos_ff};
            op_item.dirty      = state_dirty;
            op_item.bad        = card_bad;
            op_item.write_data = packed_word;
            if (pos_ff == POS_W'(WORD_BITS - 1)) begin
               op_item.write_en = 1'b1;
               if (accept) begin
                  ptr_in     = ptr_ff + 1'b1;
                  partial_in = '0;
                  pos_in     = '0;
               end
            end else if (accept) begin
               partial_in = packed_word;
               pos_in     = pos_ff + 1'b1;
            end
         end
         CMD_MARK_DIRTY: begin
            op_push      = accept;
            op_item.kind = OP_MARK;
         end
         CMD_QUERY_CARD: begin
            op_push         = accept;
            op_item.kind    = OP_QUERY;
            op_item.word    = req_item.card_index[CARD_W-1 -: ADDR_W];
            op_item.bit_pos = req_item.card_index[POS_W-1:0];
            op_item.card    = req_item.card_index;
         end
         CMD_SCAN_WORD: begin
            op_push      = accept;
            op_item.kind = OP_SCAN;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         partial_ff <= '0;
         pos_ff     <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

// ----- rtl/ccb_back.sv -----
// ----------------------------------------------------------------------------
// ccb_back
// Own the bitmap memory; carry out writes, queries and word scans.
// ----------------------------------------------------------------------------
module ccb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_empty,
   input  ccb_pkg::op_type  op_item,
   output logic             op_pop,
   output logic             rsp_push,
   output ccb_pkg::rsp_type rsp_item,
   input  logic             rsp_full
);
   import ccb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SCAN = 3'b100
   } back_state_type;

   logic [WORD_BITS-1:0] bitmap [NUM_WORDS];

   back_state_type       state_ff, state_in;
   logic                 is_scan_ff, is_scan_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [POS_W-1:0]     bit_ff, bit_in;
   logic [CARD_W-1:0]    card_ff, card_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WORD_BITS-1:0] scan_ff, scan_in;
   logic [GROUP_W-1:0]   group_ff, group_in;

   logic                 mem_we, rd_en;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [LANE_BITS-1:0] lane_bits;
   logic [LANE_W-1:0]    lane_low;
   logic [POS_W-1:0]     hit_pos;
   logic [WORD_BITS-1:0] cleared;

   assign lane_bits = scan_ff[{group_ff, LANE_W'(0)} +: LANE_BITS];

   always_comb begin
      lane_low = '0;
      for (int i = LANE_BITS - 1; i >= 0; i--) begin
         if (lane_bits[i]) begin
            lane_low = LANE_W'(i);
         end
      end
   end

   assign hit_pos = {group_ff, lane_low};
   assign cleared = scan_ff & ~(WORD_BITS'(1) << hit_pos);

   always_comb begin
      state_in   = state_ff;
      is_scan_in = is_scan_ff;
      word_in    = word_ff;
      bit_in     = bit_ff;
      card_in    = card_ff;
      scan_in    = scan_ff;
      group_in   = group_ff;
      op_pop     = 1'b0;
      rsp_push   = 1'b0;
      rsp_item   = '0;
      mem_we     = 1'b0;
      mem_wdata  = op_item.write_data;
      rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!op_empty) begin
               unique case (op_item.kind)
                  OP_CARD: begin
                     if (!rsp_full) begin
                        op_pop               = 1'b1;
                        rsp_push             = 1'b1;
                        rsp_item.card_number = op_item.card;
                        rsp_item.dirty       = op_item.dirty;
                        rsp_item.bad_state   = op_item.bad;
                        rsp_item.last        = 1'b1;
                        mem_we               = op_item.write_en;
                     end
                  end
                  OP_MARK: begin
                     op_pop    = 1'b1;
                     mem_we    = 1'b1;
                     mem_wdata = '1;
                  end
                  OP_QUERY, OP_SCAN: begin
                     op_pop     = 1'b1;
                     rd_en      = 1'b1;
                     is_scan_in = (op_item.kind == OP_SCAN);
                     word_in    = op_item.word;
                     bit_in     = op_item.bit_pos;
                     card_in    = op_item.card;
                     state_in   = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (is_scan_ff && rd_data_ff != '0) begin
               scan_in  = rd_data_ff;
               group_in = '0;
               state_in = ST_SCAN;
            end else if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_item.last = 1'b1;
               if (is_scan_ff) begin
                  rsp_item.card_number = {word_ff, POS_W'(0)};
               end else begin
                  rsp_item.card_number = card_ff;
                  rsp_item.dirty       = rd_data_ff[bit_ff];
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (lane_bits == '0) begin
               group_in = group_ff + 1'b1;
            end else if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_item.card_number = {word_ff, hit_pos};
               rsp_item.dirty       = 1'b1;
               rsp_item.last        = (cleared == '0);
               scan_in              = cleared;
               if (cleared == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      is_scan_ff <= is_scan_in;
      word_ff    <= word_in;
      bit_ff     <= bit_in;
      card_ff    <= card_in;
      scan_ff    <= scan_in;
      group_ff   <= group_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap[op_item.word] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap[op_item.word];
      end
   end

endmodule

// ----- rtl/compressed_card_bitmap_core.sv -----
// ----------------------------------------------------------------------------
// compressed_card_bitmap_core
// Card-table dirty bitmap: rebuild from card states, mark, query and scan.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                           Transfer when
//   -------   -----------------------------   -----------------------------
//   request   req_push, req_full, req_item    req_push high, req_full low
//   response  rsp_pop, rsp_empty, rsp_item    rsp_pop high, rsp_empty low
//
// Card state and mark dirty finish in the back end's idle state; begin
// rebuild and unknown commands stop in the front and never reach it.
// A query makes a registered bitmap read, then the response.
// A scan of a clean word reads the bitmap, then sends one response; a
// dirty word is read, then walked group by group from the lowest: one
// response per dirty card and a step past each eight-bit group with none;
// one bitmap read port and an eight-bit lowest-set search bound it.
// Reset clears the rebuild pointer, the partial word, the queues and the
// back-end state; bitmap words hold garbage until written.
// A full response queue stalls the back end, which fills the command queue
// and raises req_full; the front keeps classifying until that happens.
//
module compressed_card_bitmap_core #(
   parameter int unsigned OP_DEPTH  = ccb_pkg::OP_QUEUE_DEPTH,
   parameter int unsigned RSP_DEPTH = ccb_pkg::RSP_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ccb_pkg::req_type req_item,
   output logic             req_full,
   input  logic             rsp_pop,
   output ccb_pkg::rsp_type rsp_item,
   output logic             rsp_empty
);
   import ccb_pkg::*;

   // Front to command queue
   op_type  fe_op;
   logic    fe_push;
   logic    opq_full;

   // Command queue to back end
   op_type  be_op;
   logic    opq_empty;
   logic    be_pop;

   // Back end to response queue
   rsp_type be_rsp;
   logic    be_rsp_push;
   logic    rspq_full;

   // Classify items and keep the rebuild pointer / partial word.
   ccb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .op_push  (fe_push),
      .op_item  (fe_op),
      .op_full  (opq_full)
   );

   // Decouple classification from bitmap access.
   ccb_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OP_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_op),
      .full      (opq_full),
      .pop       (be_pop),
      .pop_data  (be_op),
      .empty     (opq_empty)
   );

   // Own the bitmap; write, read and walk words.
   ccb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (opq_empty),
      .op_item  (be_op),
      .op_pop   (be_pop),
      .rsp_push (be_rsp_push),
      .rsp_item (be_rsp),
      .rsp_full (rspq_full)
   );

   // Hold finished responses so the back end keeps moving while the
   // consumer stalls.
   ccb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (be_rsp_push),
      .push_data (be_rsp),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule
